// ===== src/fqc_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO queue package
// Operation codes, status codes and the command that drives the cell row.
// ----------------------------------------------------------------------------
package fqc_pkg;

    localparam logic [2:0] FUNC_PUSH   = 3'd0;
    localparam logic [2:0] FUNC_POP    = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_LOCATE = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_REFUSED  = 3'd4;

    typedef struct packed {
        logic push;
        logic shift;
    } cell_cmd_t;

endpackage

// ===== src/fqc_cell.sv =====
// ----------------------------------------------------------------------------
// FIFO queue cell
// Holds one entry, takes a pushed item or its neighbor's entry, and compares
// its id against the search key.
// ----------------------------------------------------------------------------
module fqc_cell #(
    parameter int ID_BITS = 16,
    parameter int DEPTH   = 64,
    parameter int INDEX   = 0
) (
    input  logic                         clk,
    input  fqc_pkg::cell_cmd_t           cmd,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [$clog2(DEPTH)-1:0]     drop_idx,
    input  logic [ID_BITS-1:0]           key,
    input  logic [ID_BITS-1:0]           push_id,
    input  logic [31:0]                  push_ref,
    input  logic [ID_BITS-1:0]           next_id,
    input  logic [31:0]                  next_ref,
    output logic [ID_BITS-1:0]           hold_id,
    output logic [31:0]                  hold_ref,
    output logic                         match
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        ref_reg;
    logic               match_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push && count == CW'(INDEX))
        begin
            id_reg  <= push_id;
            ref_reg <= push_ref;
        end
        else if (cmd.shift && AW'(INDEX) >= drop_idx)
        begin
            id_reg  <= next_id;
            ref_reg <= next_ref;
        end
        match_reg <= (id_reg == key) && (CW'(INDEX) < count);
    end

    assign hold_id  = id_reg;
    assign hold_ref = ref_reg;
    assign match    = match_reg;

endmodule

// ===== src/fqc_find.sv =====
// ----------------------------------------------------------------------------
// FIFO queue first-match finder
// Registered binary tree that reports the lowest cell index whose match flag
// is set, one tree level per cycle.
// ----------------------------------------------------------------------------
module fqc_find #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic [DEPTH-1:0]           match,
    output logic                       found,
    output logic [$clog2(DEPTH)-1:0]   index
);

    localparam int LV = $clog2(DEPTH);
    localparam int NP = 1 << LV;
    localparam int AW = LV;

    logic          node_f [1:2*NP-1];
    logic [AW-1:0] node_i [1:2*NP-1];
    logic          int_f_reg [1:NP-1];
    logic [AW-1:0] int_i_reg [1:NP-1];

    for (genvar n = 1; n < NP; n++)
    begin : g_node
        assign node_f[n] = int_f_reg[n];
        assign node_i[n] = int_i_reg[n];

        always_ff @(posedge clk)
        begin
            int_f_reg[n] <= node_f[2*n] | node_f[2*n+1];
            int_i_reg[n] <= node_f[2*n] ? node_i[2*n] : node_i[2*n+1];
        end
    end

    for (genvar l = 0; l < NP; l++)
    begin : g_leaf
        if (l < DEPTH)
        begin : g_used
            assign node_f[NP+l] = match[l];
        end
        else
        begin : g_pad
            assign node_f[NP+l] = 1'b0;
        end
        assign node_i[NP+l] = AW'(l);
    end

    assign found = int_f_reg[1];
    assign index = int_i_reg[1];

endmodule

// ===== src/fifo_queue_with_cancel_and_position.sv =====
// Ordered queue of up to QUEUE_DEPTH entries, each an id and a 32-bit record
// handle, held in a row of cells with the head in the first cell. Push, pop
// and clear go from the idle state straight to the execute state. Remove and
// locate first pass a compare state, in which every cell compares its id,
// and a wait state, in which a registered tree finds the first matching
// cell one level per cycle. The result is held in an output register, so a
// new item can be accepted while a result waits; the next item executes once
// the waiting result has been taken.
// ----------------------------------------------------------------------------
// FIFO queue with cancel and position
// Cell-based FIFO with push, pop, clear, remove by id and position lookup.
// ----------------------------------------------------------------------------
module fifo_queue_with_cancel_and_position #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [15:0] entry_id,
    input  logic [31:0] entry_ref,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] popped_id,
    output logic [31:0] popped_ref,
    output logic [5:0]  position,
    output logic [6:0]  occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int LV = $clog2(QUEUE_DEPTH);
    localparam int WW = $clog2(LV + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [WW-1:0]      wait_reg, wait_next;
    logic [2:0]         func_reg;
    logic [ID_BITS-1:0] key_reg;
    logic [31:0]        ref_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg;
    logic [2:0]         status_reg, status_next;
    logic [15:0]        pid_reg;
    logic [31:0]        pref_reg, pref_next;
    logic [5:0]         pos_reg;
    logic [6:0]         occ_reg;

    logic [31:0]        id_wide, pid_wide, pos_wide, occ_wide;
    logic [AW-1:0]      drop_idx, pos_idx;
    logic               in_acc, exec_go, search;
    fqc_pkg::cell_cmd_t cmd;

    logic [ID_BITS-1:0] cell_id  [QUEUE_DEPTH];
    logic [31:0]        cell_ref [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic               hit;
    logic [AW-1:0]      hit_idx;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_BITS-1:0] nid;
        logic [31:0]        nref;
        if (i + 1 < QUEUE_DEPTH)
        begin : g_mid
            assign nid  = cell_id[i+1];
            assign nref = cell_ref[i+1];
        end
        else
        begin : g_last
            assign nid  = cell_id[i];
            assign nref = cell_ref[i];
        end

        fqc_cell #(
            .ID_BITS (ID_BITS),
            .DEPTH   (QUEUE_DEPTH),
            .INDEX   (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .count    (count_reg),
            .drop_idx (drop_idx),
            .key      (key_reg),
            .push_id  (key_reg),
            .push_ref (ref_reg),
            .next_id  (nid),
            .next_ref (nref),
            .hold_id  (cell_id[i]),
            .hold_ref (cell_ref[i]),
            .match    (cell_match[i])
        );
    end

    fqc_find #(
        .DEPTH (QUEUE_DEPTH)
    ) u_find (
        .clk   (clk),
        .match (cell_match),
        .found (hit),
        .index (hit_idx)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign exec_go  = (state_reg == S_EXEC) && !(out_valid_reg && out_stall);
    assign search   = func inside {fqc_pkg::FUNC_REMOVE, fqc_pkg::FUNC_LOCATE};
    assign id_wide  = {16'd0, entry_id};

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = search ? S_CMP : S_EXEC;
                end
            end
            S_CMP:
            begin
                state_next = S_WAIT;
                wait_next  = WW'(LV);
            end
            S_WAIT:
            begin
                wait_next = wait_reg - 1'b1;
                if (wait_reg == WW'(1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        drop_idx    = '0;
        pos_idx     = '0;
        count_next  = count_reg;
        status_next = fqc_pkg::ST_OK;
        pid_wide    = '0;
        pref_next   = '0;
        case (func_reg)
            fqc_pkg::FUNC_PUSH:
            begin
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    status_next = fqc_pkg::ST_FULL;
                end
                else
                begin
                    cmd.push   = exec_go;
                    count_next = count_reg + 1'b1;
                end
            end
            fqc_pkg::FUNC_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = fqc_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.shift  = exec_go;
                    pid_wide   = 32'(cell_id[0]);
                    pref_next  = cell_ref[0];
                    count_next = count_reg - 1'b1;
                end
            end
            fqc_pkg::FUNC_REMOVE:
            begin
                drop_idx = hit_idx;
                if (!hit)
                begin
                    status_next = fqc_pkg::ST_NOTFOUND;
                end
                else if (hit_idx == '0)
                begin
                    status_next = fqc_pkg::ST_REFUSED;
                end
                else
                begin
                    cmd.shift  = exec_go;
                    count_next = count_reg - 1'b1;
                end
            end
            fqc_pkg::FUNC_LOCATE:
            begin
                if (!hit)
                begin
                    status_next = fqc_pkg::ST_NOTFOUND;
                end
                else
                begin
                    pos_idx = hit_idx;
                end
            end
            fqc_pkg::FUNC_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        pos_wide = 32'(pos_idx);
        occ_wide = 32'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (exec_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg <= func;
            key_reg  <= id_wide[ID_BITS-1:0];
            ref_reg  <= entry_ref;
        end
        if (exec_go)
        begin
            status_reg <= status_next;
            pid_reg    <= pid_wide[15:0];
            pref_reg   <= pref_next;
            pos_reg    <= pos_wide[5:0];
            occ_reg    <= occ_wide[6:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign popped_id  = pid_reg;
    assign popped_ref = pref_reg;
    assign position   = pos_reg;
    assign occupancy  = occ_reg;

    logic [31:0] cnt_wide;
    assign cnt_wide = 32'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.shift))
        else $error("Push and shift issued to the cells together.");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("Result raised outside the execute state.");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (occ_reg == cnt_wide[6:0]))
        else $error("Reported occupancy differs from the entry count.");

endmodule
